/* hdl/tsf_pkg.sv */
// ----------------------------------------------------------------------------
// Tape saturation filter package
// Shared types, constants, tables and fixed-point helpers.
// ----------------------------------------------------------------------------
package tsf_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 131;
  localparam int unsigned SAMPLE_BITS_DEF   = 24;
  localparam int unsigned TAP_COUNT         = 32;
  localparam int unsigned ARITH_STEPS       = 32;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_DATA_W        = 25;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGHPASS_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_DECAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_DECAY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = 3'd5;

  localparam logic [23:0] RST_INPUT_GAIN    = 24'd1048576;
  localparam logic [23:0] RST_HIGHPASS_COEF = 24'd1287554;
  localparam logic [24:0] RST_FAST_DECAY    = 25'd5242880;
  localparam logic [24:0] RST_SLOW_DECAY    = 25'd16746460;
  localparam logic [23:0] RST_OUTPUT_SCALE  = 24'd2162688;
  localparam logic [23:0] RST_OUTPUT_GAIN   = 24'd1048576;

  // Sine argument limit, pi/2 in Q.32, and one in Q.30.
  localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  typedef logic signed [39:0] s40_t;
  typedef logic signed [49:0] wide_t;
  typedef logic [71:0]        prod_t;

  typedef enum logic {
    ARITH_MUL,
    ARITH_DIV
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HP_MUL,
    S_IG_MUL,
    S_SIN0,
    S_SQ,
    S_TM,
    S_DV,
    S_SF,
    S_FS_MUL,
    S_TAP,
    S_SS_MUL,
    S_SD_MUL,
    S_OS_MUL,
    S_OG_MUL,
    S_OUT
  } seq_state_e;

  // History taps relative to the newest word, grouped by weight.
  localparam logic [7:0] TAP_OFFSET [TAP_COUNT] = '{
    8'd130, 8'd116, 8'd112, 8'd110, 8'd106, 8'd104, 8'd100, 8'd92, 8'd86,
    8'd82, 8'd76, 8'd74, 8'd70, 8'd64, 8'd62, 8'd56, 8'd50, 8'd46, 8'd44,
    8'd40, 8'd34, 8'd32,
    8'd26, 8'd22, 8'd20, 8'd16, 8'd14,
    8'd10, 8'd8, 8'd6,
    8'd5, 8'd4
  };
  localparam logic [2:0] TAP_SHIFT [TAP_COUNT] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3,
    3'd4, 3'd4
  };

  // Divisors of the nested Taylor series, innermost first.
  localparam logic [7:0] SINE_DIV [6] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

  // Saturate to the 40-bit signed range.
  function automatic s40_t sat40(wide_t v);
    s40_t r;
    if ((&v[49:39]) || !(|v[49:39])) begin
      r = v[39:0];
    end else if (v[49]) begin
      r = {1'b1, 39'd0};
    end else begin
      r = {1'b0, {39{1'b1}}};
    end
    return r;
  endfunction

  // Magnitude of a 40-bit signed value.
  function automatic logic [39:0] mag40(s40_t v);
    logic [39:0] r;
    r = v[39] ? 40'(-v) : 40'(v);
    return r;
  endfunction

  // Round an unsigned product right by sh bits, ties away from zero, then sign it.
  function automatic wide_t mulr_post(prod_t p, int unsigned sh, logic neg);
    prod_t       r;
    logic [48:0] m;
    wide_t       w;
    r = (p + (prod_t'(1) << (sh - 1))) >> sh;
    m = r[48:0];
    w = wide_t'({1'b0, m});
    return neg ? -w : w;
  endfunction

endpackage

/* hdl/tsf_ram.sv */
// ----------------------------------------------------------------------------
// Tape saturation filter RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module tsf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 131
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/tsf_arith.sv */
// ----------------------------------------------------------------------------
// Tape saturation filter arithmetic unit
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module tsf_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsf_pkg::arith_req_t req_i,
  input  logic [39:0]         opa_i,
  input  logic [31:0]         opb_i,
  output tsf_pkg::prod_t      res_o,
  output logic                done_o
);

  localparam int unsigned CNT_W = $clog2(tsf_pkg::ARITH_STEPS + 1);

  tsf_pkg::prod_t     acc_q, acc_d;
  logic [39:0]        a_q;
  logic [7:0]         rem_q, rem_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  tsf_pkg::arith_op_e op_q;
  logic [40:0]        sum;
  logic [8:0]         trial;
  logic               ge;

  always_comb begin
    sum   = {1'b0, acc_q[71:32]} + (acc_q[0] ? {1'b0, a_q} : 41'd0);
    trial = {rem_q, acc_q[31]};
    ge    = trial >= {1'b0, a_q[7:0]};
    acc_d  = acc_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      cnt_d = CNT_W'(tsf_pkg::ARITH_STEPS);
      rem_d = '0;
      if (req_i.op == tsf_pkg::ARITH_DIV) begin
        acc_d = tsf_pkg::prod_t'(opa_i[31:0]);
      end else begin
        acc_d = tsf_pkg::prod_t'(opb_i);
      end
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
      if (op_q == tsf_pkg::ARITH_MUL) begin
        acc_d = {sum, acc_q[31:1]};
      end else begin
        rem_d = ge ? 8'(trial - {1'b0, a_q[7:0]}) : trial[7:0];
        acc_d = {acc_q[71:32], acc_q[30:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      op_q <= req_i.op;
      a_q  <= (req_i.op == tsf_pkg::ARITH_DIV) ? 40'(opb_i[7:0]) : opa_i;
    end
  end

  assign res_o  = acc_q;
  assign done_o = done_q;

endmodule

/* hdl/tape_saturation_filter.sv */
// ----------------------------------------------------------------------------
// Tape saturation filter
// Highpass, sine saturation, tapped history and leaky integrators per sample.
// ----------------------------------------------------------------------------
// One signed sample word enters and one processed sample word leaves. The
// work runs as 35 passes through one bit-serial multiply/divide unit, each
// pass 32 serial steps plus launch and capture, plus a sweep that reads
// the 32 history taps from the history RAM one per cycle. A new word is
// taken only while the sequencer is idle; the finished word waits in an
// output register, so the next word can be taken while it is still
// stalled. Two sets of highpass and integrator state alternate on every
// sample, starting with set A; both sets share one history. The history is
// cleared by reset through one valid bit per entry, so no clearing pass is
// needed. Configuration registers are written through the cfg port, which
// is always ready, and should only be changed while the filter is idle.
// ----------------------------------------------------------------------------
module tape_saturation_filter #(
  parameter int unsigned HISTORY_DEPTH = tsf_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS   = tsf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]     sample_out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tsf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tsf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned FRAC   = SAMPLE_BITS - 1;
  localparam int unsigned PTR_W  = $clog2(HISTORY_DEPTH);
  localparam int unsigned X_SH   = 32 - FRAC;
  localparam int unsigned TFROM  = FRAC + 11;
  localparam int unsigned TSUM_W = SAMPLE_BITS + 10;
  localparam int unsigned TI_W   = $clog2(tsf_pkg::TAP_COUNT);
  localparam int unsigned TC_W   = TI_W + 1;

  localparam logic [33:0]   S_MAX = 34'((64'd1 << FRAC) - 64'd1);
  localparam tsf_pkg::s40_t O_MAX = tsf_pkg::s40_t'((64'sd1 <<< FRAC) - 64'sd1);
  localparam tsf_pkg::s40_t O_MIN = -O_MAX - 40'sd1;

  // Sequencer.
  tsf_pkg::seq_state_e state_q, state_d;
  logic                issue_q;
  logic                pass_q;
  logic [2:0]          k_q;
  logic [TC_W-1:0]     tap_cnt_q;

  // Configuration registers.
  logic [23:0] ig_q, hpc_q, os_q, og_q;
  logic [24:0] fd_q, sd_q;

  // Filter state; phase_q high selects set A.
  tsf_pkg::s40_t    hp_q [2];
  tsf_pkg::s40_t    fs_q [2];
  tsf_pkg::s40_t    ss_q [2];
  logic             phase_q;
  logic [PTR_W-1:0] pos_q;
  logic [HISTORY_DEPTH-1:0] hvalid_q;

  // Working registers.
  tsf_pkg::s40_t             x_q, v_q;
  logic [30:0]               x30_q, t_q;
  logic [31:0]               x2_q, q_q;
  logic                      sneg_q;
  logic signed [SAMPLE_BITS-1:0] s_q;
  logic signed [TSUM_W-1:0]  tsum_q;
  logic                      rd_pend_q, hv_q;
  logic [2:0]                sh_q;
  logic                      out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_q;

  // Arithmetic unit connection.
  tsf_pkg::arith_req_t arith_req;
  logic [39:0]         arith_opa;
  logic [31:0]         arith_opb;
  tsf_pkg::prod_t      arith_res;
  logic                arith_done;
  logic                arith_state;
  logic                mul_neg;

  logic                set_sel;
  tsf_pkg::s40_t       hp_cur, fs_cur, ss_cur, hp_diff;
  logic                in_take, out_load;

  assign set_sel = ~phase_q;
  assign hp_cur  = hp_q[set_sel];
  assign fs_cur  = fs_q[set_sel];
  assign ss_cur  = ss_q[set_sel];
  assign hp_diff = tsf_pkg::sat40(tsf_pkg::wide_t'(x_q) - tsf_pkg::wide_t'(hp_cur));

  assign in_take  = (state_q == tsf_pkg::S_IDLE) && in_valid_i;
  assign out_load = (state_q == tsf_pkg::S_OUT) && (!out_valid_q || !out_stall_i);

  // Sine argument: magnitude clamped at pi/2 and rounded to Q.30.
  logic [39:0] v_mag, v_clamp;
  logic [30:0] x30_next;
  always_comb begin
    v_mag    = tsf_pkg::mag40(v_q);
    v_clamp  = (v_mag > 40'(tsf_pkg::HALF_PI_Q32)) ? 40'(tsf_pkg::HALF_PI_Q32) : v_mag;
    x30_next = 31'((v_clamp + 40'd2) >> 2);
  end

  // Sine result: Q.30 product rounded to the sample format and clamped.
  logic [32:0]                   s30;
  logic [33:0]                   s_rnd, s_lim;
  logic signed [SAMPLE_BITS-1:0] sine_val;
  assign s30 = arith_res[62:30];
  if (FRAC < 30) begin : g_sine_down
    assign s_rnd = ({1'b0, s30} + (34'd1 << (29 - FRAC))) >> (30 - FRAC);
  end else begin : g_sine_up
    assign s_rnd = {1'b0, s30} << (FRAC - 30);
  end
  assign s_lim    = (s_rnd > S_MAX) ? S_MAX : s_rnd;
  assign sine_val = sneg_q ? -$signed(SAMPLE_BITS'(s_lim)) : $signed(SAMPLE_BITS'(s_lim));

  // Weighted tap sum brought to Q.32, ties toward plus infinity.
  tsf_pkg::wide_t tap_scaled;
  if (TFROM > 32) begin : g_tap_down
    assign tap_scaled = (tsf_pkg::wide_t'(tsum_q) + (tsf_pkg::wide_t'(1) <<< (TFROM - 33)))
                        >>> (TFROM - 32);
  end else begin : g_tap_up
    assign tap_scaled = tsf_pkg::wide_t'(tsum_q) <<< (32 - TFROM);
  end

  // History tap address, modulo the depth.
  logic [TI_W-1:0]  tap_i;
  logic [PTR_W:0]   tap_sum;
  logic [PTR_W-1:0] tap_addr;
  logic [SAMPLE_BITS-1:0] hist_rdata;
  logic                   hist_we;
  logic signed [TSUM_W-1:0] tap_term;
  always_comb begin
    tap_i    = tap_cnt_q[TI_W-1:0];
    tap_sum  = {1'b0, pos_q} + (PTR_W+1)'(tsf_pkg::TAP_OFFSET[tap_i]);
    tap_addr = (tap_sum >= (PTR_W+1)'(HISTORY_DEPTH))
               ? PTR_W'(tap_sum - (PTR_W+1)'(HISTORY_DEPTH)) : tap_sum[PTR_W-1:0];
    tap_term = hv_q ? (TSUM_W'($signed(hist_rdata)) <<< sh_q) : '0;
  end

  assign hist_we = (state_q == tsf_pkg::S_FS_MUL) && issue_q;

  tsf_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (hist_we),
    .waddr_i(pos_q),
    .wdata_i(s_q),
    .raddr_i(tap_addr),
    .rdata_o(hist_rdata)
  );

  tsf_arith u_arith (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (arith_req),
    .opa_i (arith_opa),
    .opb_i (arith_opb),
    .res_o (arith_res),
    .done_o(arith_done)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tsf_pkg::S_IDLE:   if (in_valid_i) state_d = tsf_pkg::S_HP_MUL;
      tsf_pkg::S_HP_MUL: if (arith_done) state_d = tsf_pkg::S_IG_MUL;
      tsf_pkg::S_IG_MUL: if (arith_done) state_d = tsf_pkg::S_SIN0;
      tsf_pkg::S_SIN0:   state_d = tsf_pkg::S_SQ;
      tsf_pkg::S_SQ:     if (arith_done) state_d = tsf_pkg::S_TM;
      tsf_pkg::S_TM:     if (arith_done) state_d = tsf_pkg::S_DV;
      tsf_pkg::S_DV: begin
        if (arith_done) state_d = (k_q == 3'd5) ? tsf_pkg::S_SF : tsf_pkg::S_TM;
      end
      tsf_pkg::S_SF: begin
        if (arith_done) state_d = pass_q ? tsf_pkg::S_OG_MUL : tsf_pkg::S_FS_MUL;
      end
      tsf_pkg::S_FS_MUL: if (arith_done) state_d = tsf_pkg::S_TAP;
      tsf_pkg::S_TAP: begin
        if (tap_cnt_q == TC_W'(tsf_pkg::TAP_COUNT)) state_d = tsf_pkg::S_SS_MUL;
      end
      tsf_pkg::S_SS_MUL: if (arith_done) state_d = tsf_pkg::S_SD_MUL;
      tsf_pkg::S_SD_MUL: if (arith_done) state_d = tsf_pkg::S_OS_MUL;
      tsf_pkg::S_OS_MUL: if (arith_done) state_d = tsf_pkg::S_SIN0;
      tsf_pkg::S_OG_MUL: if (arith_done) state_d = tsf_pkg::S_OUT;
      tsf_pkg::S_OUT:    if (out_load) state_d = tsf_pkg::S_IDLE;
      default:           state_d = tsf_pkg::S_IDLE;
    endcase
  end

  // Operand selection for the arithmetic unit. Each arithmetic state starts
  // the unit in its first cycle and waits for the done pulse.
  always_comb begin
    arith_state = 1'b0;
    arith_opa   = '0;
    arith_opb   = '0;
    mul_neg     = 1'b0;
    case (state_q)
      tsf_pkg::S_HP_MUL: begin
        arith_state = 1'b1;
        arith_opa   = tsf_pkg::mag40(hp_diff);
        arith_opb   = 32'(hpc_q);
        mul_neg     = hp_diff[39];
      end
      tsf_pkg::S_IG_MUL: begin
        arith_state = 1'b1;
        arith_opa   = tsf_pkg::mag40(hp_diff);
        arith_opb   = 32'(ig_q);
        mul_neg     = hp_diff[39];
      end
      tsf_pkg::S_SQ: begin
        arith_state = 1'b1;
        arith_opa   = 40'(x30_q);
        arith_opb   = 32'(x30_q);
      end
      tsf_pkg::S_TM: begin
        arith_state = 1'b1;
        arith_opa   = 40'(x2_q);
        arith_opb   = 32'(t_q);
      end
      tsf_pkg::S_DV: begin
        arith_state = 1'b1;
        arith_opa   = 40'(q_q);
        arith_opb   = 32'(tsf_pkg::SINE_DIV[k_q]);
      end
      tsf_pkg::S_SF: begin
        arith_state = 1'b1;
        arith_opa   = 40'(x30_q);
        arith_opb   = 32'(t_q);
      end
      tsf_pkg::S_FS_MUL: begin
        arith_state = 1'b1;
        arith_opa   = tsf_pkg::mag40(fs_cur);
        arith_opb   = 32'(fd_q);
        mul_neg     = fs_cur[39];
      end
      tsf_pkg::S_SS_MUL, tsf_pkg::S_SD_MUL: begin
        arith_state = 1'b1;
        arith_opa   = tsf_pkg::mag40(ss_cur);
        arith_opb   = 32'(sd_q);
        mul_neg     = ss_cur[39];
      end
      tsf_pkg::S_OS_MUL: begin
        arith_state = 1'b1;
        arith_opa   = tsf_pkg::mag40(v_q);
        arith_opb   = 32'(os_q);
        mul_neg     = v_q[39];
      end
      tsf_pkg::S_OG_MUL: begin
        arith_state = 1'b1;
        arith_opa   = tsf_pkg::mag40(tsf_pkg::s40_t'(s_q));
        arith_opb   = 32'(og_q);
        mul_neg     = s_q[SAMPLE_BITS-1];
      end
      default: begin
        arith_state = 1'b0;
      end
    endcase
    arith_req.start = issue_q && arith_state;
    arith_req.op    = (state_q == tsf_pkg::S_DV) ? tsf_pkg::ARITH_DIV : tsf_pkg::ARITH_MUL;
  end

  // Control state, filter state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsf_pkg::S_IDLE;
      issue_q     <= 1'b0;
      pass_q      <= 1'b0;
      k_q         <= '0;
      tap_cnt_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b1;
      pos_q       <= '0;
      hvalid_q    <= '0;
      hp_q[0]     <= '0;
      hp_q[1]     <= '0;
      fs_q[0]     <= '0;
      fs_q[1]     <= '0;
      ss_q[0]     <= '0;
      ss_q[1]     <= '0;
      ig_q        <= tsf_pkg::RST_INPUT_GAIN;
      hpc_q       <= tsf_pkg::RST_HIGHPASS_COEF;
      fd_q        <= tsf_pkg::RST_FAST_DECAY;
      sd_q        <= tsf_pkg::RST_SLOW_DECAY;
      os_q        <= tsf_pkg::RST_OUTPUT_SCALE;
      og_q        <= tsf_pkg::RST_OUTPUT_GAIN;
    end else begin
      state_q   <= state_d;
      issue_q   <= (state_d != state_q);
      rd_pend_q <= (state_q == tsf_pkg::S_TAP) && (tap_cnt_q != TC_W'(tsf_pkg::TAP_COUNT));

      if (cfg_valid_i) begin
        case (cfg_index_i)
          tsf_pkg::REG_INPUT_GAIN:    ig_q  <= cfg_data_i[23:0];
          tsf_pkg::REG_HIGHPASS_COEF: hpc_q <= cfg_data_i[23:0];
          tsf_pkg::REG_FAST_DECAY:    fd_q  <= cfg_data_i;
          tsf_pkg::REG_SLOW_DECAY:    sd_q  <= cfg_data_i;
          tsf_pkg::REG_OUTPUT_SCALE:  os_q  <= cfg_data_i[23:0];
          tsf_pkg::REG_OUTPUT_GAIN:   og_q  <= cfg_data_i[23:0];
          default: begin
          end
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        tsf_pkg::S_IDLE: begin
          if (in_take) pass_q <= 1'b0;
        end
        tsf_pkg::S_HP_MUL: begin
          if (arith_done) begin
            hp_q[set_sel] <= tsf_pkg::sat40(tsf_pkg::wide_t'(hp_cur)
                             + tsf_pkg::mulr_post(arith_res, 24, mul_neg));
          end
        end
        tsf_pkg::S_SQ: begin
          if (arith_done) k_q <= '0;
        end
        tsf_pkg::S_DV: begin
          if (arith_done) k_q <= k_q + 3'd1;
        end
        tsf_pkg::S_FS_MUL: begin
          tap_cnt_q <= '0;
          if (issue_q) hvalid_q[pos_q] <= 1'b1;
          if (arith_done) begin
            fs_q[set_sel] <= tsf_pkg::sat40(tsf_pkg::mulr_post(arith_res, 24, mul_neg)
                             + (tsf_pkg::wide_t'(s_q) <<< X_SH));
          end
        end
        tsf_pkg::S_TAP: begin
          if (tap_cnt_q != TC_W'(tsf_pkg::TAP_COUNT)) tap_cnt_q <= tap_cnt_q + 1'b1;
        end
        tsf_pkg::S_SS_MUL: begin
          if (arith_done) begin
            ss_q[set_sel] <= tsf_pkg::sat40(tsf_pkg::mulr_post(arith_res, 24, mul_neg)
                             + tap_scaled);
          end
        end
        tsf_pkg::S_OS_MUL: begin
          if (arith_done) pass_q <= 1'b1;
        end
        tsf_pkg::S_OUT: begin
          if (out_load) begin
            phase_q <= ~phase_q;
            pos_q   <= (pos_q == '0) ? PTR_W'(HISTORY_DEPTH - 1) : pos_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    sh_q <= tsf_pkg::TAP_SHIFT[tap_i];
    hv_q <= hvalid_q[tap_addr];
    case (state_q)
      tsf_pkg::S_IDLE: begin
        if (in_take) x_q <= tsf_pkg::s40_t'(sample_in_i) <<< X_SH;
      end
      tsf_pkg::S_IG_MUL: begin
        if (arith_done) v_q <= tsf_pkg::sat40(tsf_pkg::mulr_post(arith_res, 20, mul_neg));
      end
      tsf_pkg::S_SIN0: begin
        x30_q  <= x30_next;
        sneg_q <= v_q[39];
      end
      tsf_pkg::S_SQ: begin
        if (arith_done) begin
          x2_q <= arith_res[61:30];
          t_q  <= tsf_pkg::ONE_Q30;
        end
      end
      tsf_pkg::S_TM: begin
        if (arith_done) q_q <= arith_res[61:30];
      end
      tsf_pkg::S_DV: begin
        if (arith_done) t_q <= tsf_pkg::ONE_Q30 - arith_res[30:0];
      end
      tsf_pkg::S_SF: begin
        if (arith_done) s_q <= sine_val;
      end
      tsf_pkg::S_FS_MUL: begin
        tsum_q <= '0;
      end
      tsf_pkg::S_TAP: begin
        if (rd_pend_q) tsum_q <= tsum_q + tap_term;
      end
      tsf_pkg::S_SD_MUL: begin
        if (arith_done) begin
          v_q <= tsf_pkg::sat40(tsf_pkg::wide_t'(fs_cur)
                 - tsf_pkg::mulr_post(arith_res, 24, mul_neg));
        end
      end
      tsf_pkg::S_OS_MUL, tsf_pkg::S_OG_MUL: begin
        if (arith_done) v_q <= tsf_pkg::sat40(tsf_pkg::mulr_post(arith_res, 20, mul_neg));
      end
      tsf_pkg::S_OUT: begin
        if (out_load) begin
          if (v_q > O_MAX) begin
            out_q <= O_MAX[SAMPLE_BITS-1:0];
          end else if (v_q < O_MIN) begin
            out_q <= O_MIN[SAMPLE_BITS-1:0];
          end else begin
            out_q <= v_q[SAMPLE_BITS-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o   = (state_q != tsf_pkg::S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;
  assign cfg_ready_o  = 1'b1;

  // The serial unit only reports completion while an arithmetic step waits.
  a_done_in_arith: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_done |-> arith_state)
    else $error("arithmetic done outside an arithmetic step");

  // The history pointer stays inside the history.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < (PTR_W+1)'(HISTORY_DEPTH))
    else $error("history pointer out of range");

  // A result word appears only from the output step.
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == tsf_pkg::S_OUT)
    else $error("output word raised outside the output step");

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Tape saturation filter testbench
// Drives sample words through the filter under random input gaps and output
// stalls, predicts every output word with a bit-exact fixed-point model of
// its own, and compares each result in order. Registers are reprogrammed
// between phases, only while the filter is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DEPTH     = 131;
  localparam int unsigned SBITS     = 24;
  localparam int unsigned FRAC      = SBITS - 1;
  localparam longint      MAX40     = 64'sd549755813887;
  localparam longint      MIN40     = -64'sd549755813888;
  localparam longint      CYCLE_CAP = 64'd12000000;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             in_valid_i;
  logic                             in_stall_o;
  logic signed [SBITS-1:0]          sample_in_i;
  logic                             out_valid_o;
  logic                             out_stall_i;
  logic signed [SBITS-1:0]          sample_out_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [tsf_pkg::CFG_IDX_W-1:0]    cfg_index_i;
  logic [tsf_pkg::CFG_DATA_W-1:0]   cfg_data_i;

  tape_saturation_filter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // The model's own copy of the registers and the filter state.
  longint unsigned gain_in, hp_coef, decay_fast, decay_slow, scale_out, gain_out;
  longint          hp_state [2];
  longint          fast_int [2];
  longint          slow_int [2];
  int              tape_hist [DEPTH];
  int unsigned     head_pos;
  bit              use_set_a;

  logic [SBITS-1:0] expected_words [$];
  int               error_count;
  int               words_sent;
  int               words_checked;
  int               cfg_writes;
  longint           cycle_count;
  bit               quiet;   // no gaps and no stalls while set

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // -------------------------------------------------------------- model --
  function automatic longint clip40(longint v);
    if (v > MAX40) return MAX40;
    if (v < MIN40) return MIN40;
    return v;
  endfunction

  // Move the binary point; right moves round with ties toward plus infinity.
  function automatic longint requant(longint v, int from, int to);
    longint w;
    longint unsigned m;
    int s;
    if (from > to) begin
      s = from - to;
      w = v + (64'sd1 <<< (s - 1));
      if (w >= 0) return w >>> s;
      m = longint'(-w);
      return -longint'((m + ((64'd1 << s) - 1)) >> s);
    end
    return v <<< (to - from);
  endfunction

  // Signed times unsigned register, rounded right by s, ties away from zero.
  function automatic longint reg_mul(longint a, longint unsigned b, int s);
    logic [127:0] p;
    longint unsigned mag;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    p = ({64'd0, mag} * {64'd0, b} + (128'd1 << (s - 1))) >> s;
    return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  // Sine of a Q.32 argument clamped at pi/2, Q.23 result.
  function automatic longint soft_clip(longint z);
    longint unsigned mag, x30, x2, t, s;
    longint r;
    if (z == 0) return 0;
    mag = (z < 0) ? longint'(-z) : longint'(z);
    if (mag > 64'd6746518852) mag = 64'd6746518852;
    x30 = (mag + 2) >> 2;
    x2  = (x30 * x30) >> 30;
    t   = 64'd1 << 30;
    for (int i = 0; i < 6; i++) begin
      t = (64'd1 << 30) - ((x2 * t) >> 30) / longint'(tsf_pkg::SINE_DIV[i]);
    end
    s = (x30 * t) >> 30;
    r = requant(longint'(s), 30, FRAC);
    if (r > (64'sd1 <<< FRAC) - 1) r = (64'sd1 <<< FRAC) - 1;
    return (z < 0) ? -r : r;
  endfunction

  function automatic void model_reset();
    gain_in    = tsf_pkg::RST_INPUT_GAIN;
    hp_coef    = tsf_pkg::RST_HIGHPASS_COEF;
    decay_fast = tsf_pkg::RST_FAST_DECAY;
    decay_slow = tsf_pkg::RST_SLOW_DECAY;
    scale_out  = tsf_pkg::RST_OUTPUT_SCALE;
    gain_out   = tsf_pkg::RST_OUTPUT_GAIN;
    for (int i = 0; i < 2; i++) begin
      hp_state[i] = 0;
      fast_int[i] = 0;
      slow_int[i] = 0;
    end
    for (int i = 0; i < DEPTH; i++) tape_hist[i] = 0;
    head_pos  = 0;
    use_set_a = 1'b1;
  endfunction

  function automatic void model_write(logic [tsf_pkg::CFG_IDX_W-1:0] idx,
                                      logic [tsf_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      tsf_pkg::REG_INPUT_GAIN:    gain_in    = d[23:0];
      tsf_pkg::REG_HIGHPASS_COEF: hp_coef    = d[23:0];
      tsf_pkg::REG_FAST_DECAY:    decay_fast = d;
      tsf_pkg::REG_SLOW_DECAY:    decay_slow = d;
      tsf_pkg::REG_OUTPUT_SCALE:  scale_out  = d[23:0];
      tsf_pkg::REG_OUTPUT_GAIN:   gain_out   = d[23:0];
      default: ;
    endcase
  endfunction

  // One sample through the whole chain; returns the output word.
  function automatic logic [SBITS-1:0] filter_sample(logic signed [SBITS-1:0] word);
    longint x, y, s, taps, diff, o;
    int set;
    int unsigned pos;
    set = use_set_a ? 0 : 1;
    x = requant(longint'(word), FRAC, 32);
    hp_state[set] = clip40(hp_state[set] + reg_mul(clip40(x - hp_state[set]), hp_coef, 24));
    y = clip40(x - hp_state[set]);
    y = clip40(reg_mul(y, gain_in, 20));
    s = soft_clip(y);
    if (head_pos >= DEPTH) head_pos = DEPTH - 1;
    pos = head_pos;
    tape_hist[pos] = int'(s);
    fast_int[set] = clip40(reg_mul(fast_int[set], decay_fast, 24) + requant(s, FRAC, 32));
    taps = 0;
    for (int i = 0; i < tsf_pkg::TAP_COUNT; i++) begin
      taps += longint'(tape_hist[(pos + tsf_pkg::TAP_OFFSET[i]) % DEPTH])
              <<< tsf_pkg::TAP_SHIFT[i];
    end
    slow_int[set] = clip40(reg_mul(slow_int[set], decay_slow, 24)
                           + requant(taps, FRAC + 11, 32));
    diff = clip40(fast_int[set] - reg_mul(slow_int[set], decay_slow, 24));
    diff = clip40(reg_mul(diff, scale_out, 20));
    o = reg_mul(soft_clip(diff), gain_out, 20);
    if (o > (64'sd1 <<< FRAC) - 1) o = (64'sd1 <<< FRAC) - 1;
    if (o < -(64'sd1 <<< FRAC)) o = -(64'sd1 <<< FRAC);
    use_set_a = !use_set_a;
    head_pos  = (pos == 0) ? DEPTH - 1 : pos - 1;
    return o[SBITS-1:0];
  endfunction

  // ------------------------------------------------- prediction & check --
  // Everything is sampled at the clock edge, before any driven value of
  // this edge lands, so each accepted word and each register write is
  // seen exactly once and in order.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (cfg_valid_i && cfg_ready_o) model_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) expected_words.push_back(filter_sample(sample_in_i));
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected output word %h", $time, sample_out_o);
          error_count++;
        end else begin
          if (sample_out_o !== expected_words[0]) begin
            $display("%0t: sample_out mismatch, expected %h actual %h",
                     $time, expected_words[0], sample_out_o);
            error_count++;
          end
          void'(expected_words.pop_front());
          words_checked++;
        end
      end
      if (cycle_count > CYCLE_CAP) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Output stall: mostly short bursts, now and then a long one.
  int stall_left;
  always @(posedge clk_i) begin
    if (quiet || !rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(99) < 15) begin
      out_stall_i <= 1'b1;
      stall_left  <= ($urandom_range(19) == 0) ? $urandom_range(300, 30) : $urandom_range(4);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ------------------------------------------------------------ drivers --
  function automatic int pick_gap();
    if (quiet) return 0;
    if ($urandom_range(19) == 0) return $urandom_range(2000, 100);
    if ($urandom_range(2) == 0) return 0;
    return $urandom_range(6);
  endfunction

  // Hands one sample word to the filter. Stall only moves at the rising
  // edge, so its value at the falling edge tells whether the next rising
  // edge takes the word.
  task automatic send_word(logic signed [SBITS-1:0] word);
    int gap;
    bit stalled;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= word;
    forever begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
      if (!stalled) break;
    end
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [tsf_pkg::CFG_IDX_W-1:0] idx,
                           logic [tsf_pkg::CFG_DATA_W-1:0] d);
    bit ready;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    forever begin
      @(negedge clk_i);
      ready = cfg_ready_o;
      @(posedge clk_i);
      if (ready) break;
    end
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic program_all(logic [24:0] ig, logic [24:0] hc, logic [24:0] fd,
                             logic [24:0] sd, logic [24:0] os, logic [24:0] og);
    wait_idle();
    write_reg(tsf_pkg::REG_INPUT_GAIN, ig);
    write_reg(tsf_pkg::REG_HIGHPASS_COEF, hc);
    write_reg(tsf_pkg::REG_FAST_DECAY, fd);
    write_reg(tsf_pkg::REG_SLOW_DECAY, sd);
    write_reg(tsf_pkg::REG_OUTPUT_SCALE, os);
    write_reg(tsf_pkg::REG_OUTPUT_GAIN, og);
  endtask

  function automatic logic signed [SBITS-1:0] random_word();
    case ($urandom_range(3))
      0: return SBITS'($urandom());
      1: return SBITS'($signed(12'($urandom())));
      2: return ($urandom_range(1)) ? 24'sh7FFFFF : 24'sh800000;
      default: return SBITS'($signed(20'($urandom())));
    endcase
  endfunction

  // -------------------------------------------------------------- tests --
  // Field extremes, steps and sign flips at the reset settings; the two
  // state sets see different words, so their separation shows.
  task automatic test_directed_extremes();
    logic signed [SBITS-1:0] pattern [$];
    pattern = '{24'sh000000, 24'sh7FFFFF, 24'sh800000, 24'sh000001, 24'shFFFFFF,
                24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh555555,
                24'shAAAAAA, 24'sh400000, 24'shC00000, 24'sh000000, 24'sh000000,
                24'sh123456, 24'shEDCBA9, 24'sh7FFFFF, 24'sh000000, 24'sh800000};
    foreach (pattern[i]) send_word(pattern[i]);
  endtask

  // Register extremes: zero gains, full-scale gains, unity and above-unity
  // decays that drive the integrators into their limits, and writes to the
  // unused indexes, which must leave every register alone.
  task automatic test_register_extremes();
    program_all(25'h0, 25'h0, 25'h0, 25'h0, 25'h0, 25'h0);
    repeat (6) send_word(random_word());
    program_all(25'hFFFFFF, 25'hFFFFFF, 25'h1000000, 25'h1000000, 25'hFFFFFF, 25'hFFFFFF);
    repeat (8) send_word(24'sh7FFFFF);
    repeat (4) send_word(24'sh800000);
    program_all(25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF,
                25'h1FFFFFF);
    wait_idle();
    write_reg(3'd6, 25'h0);
    write_reg(3'd7, 25'h0);
    repeat (10) send_word(random_word());
  endtask

  // Runs long enough to wrap the history many times, with several random
  // register settings and one stretch without gaps or stalls.
  task automatic test_random_program();
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        program_all(25'(tsf_pkg::RST_INPUT_GAIN), 25'(tsf_pkg::RST_HIGHPASS_COEF),
                    tsf_pkg::RST_FAST_DECAY, tsf_pkg::RST_SLOW_DECAY,
                    25'(tsf_pkg::RST_OUTPUT_SCALE), 25'(tsf_pkg::RST_OUTPUT_GAIN));
      end else begin
        program_all(25'($urandom()), 25'($urandom()), 25'($urandom_range(25'h1000000)),
                    25'($urandom_range(25'h1000000, 25'hF00000)), 25'($urandom()),
                    25'($urandom_range(25'h400000)));
      end
      quiet = (phase == 3);
      for (int n = 0; n < 140; n++) begin
        send_word(random_word());
        // Let the filter drain completely once, midway through phase five.
        if (n == 70 && phase == 5) wait_idle();
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    error_count = 0;
    words_sent = 0;
    words_checked = 0;
    cfg_writes = 0;
    cycle_count = 0;
    quiet = 1'b0;
    model_reset();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_register_extremes();
    test_random_program();

    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (1300) @(posedge clk_i);

    $display("Sent %0d samples and checked %0d outputs across %0d register writes,",
             words_sent, words_checked, cfg_writes);
    $display("including zero, full-scale and above-unity settings and both state sets.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
